/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// Needs clk and rst_n in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LCFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lcfp_pkg.sv */
// Package for the length/checksum frame parser: constants, status codes, byte slots.
// No dependencies.
package lcfp_pkg;

    localparam int MAX_FRAME_BYTES = 14;
    localparam int MIN_FRAME_BYTES = 6;
    localparam int DATA_DEPTH      = 8;
    localparam int HEADER_BYTES    = 5;
    localparam int DATA_IDX_W      = $clog2(DATA_DEPTH);
    localparam int DCOUNT_W        = 4;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Header slot positions within a frame
    localparam logic [7:0] IDX_LENGTH    = 8'd0;
    localparam logic [7:0] IDX_AXIS_HI   = 8'd1;
    localparam logic [7:0] IDX_AXIS_LO   = 8'd2;
    localparam logic [7:0] IDX_OPCODE_HI = 8'd3;
    localparam logic [7:0] IDX_OPCODE_LO = 8'd4;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_SIZE = 2'd1,
        STATUS_BAD_SUM  = 2'd2
    } lcfp_status_t;

endpackage

/* hdl/lcfp_byte_if.sv */
// Handshake channel for received bytes.
// Depends on nothing.
interface lcfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

/* hdl/lcfp_result_if.sv */
// Handshake channel for parsed frame results.
// Depends on nothing.
interface lcfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  frame_size;
    logic [11:0] axis_id;
    logic [15:0] command_code;
    logic [3:0]  data_count;
    logic [63:0] data_payload;

    modport source (output valid, output status, output frame_size, output axis_id,
                    output command_code, output data_count, output data_payload,
                    input ready);
    modport sink   (input valid, input status, input frame_size, input axis_id,
                    input command_code, input data_count, input data_payload,
                    output ready);
endinterface

/* hdl/lcfp_in_stage.sv */
// Input register stage for received byte beats.
// Depends on lcfp_byte_if.
module lcfp_in_stage
(
    input  logic        clk,
    input  logic        rst_n,
    lcfp_byte_if.sink   up,
    lcfp_byte_if.source down
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    assign up.ready       = !valid_reg || down.ready;
    assign down.valid     = valid_reg;
    assign down.rx_byte   = byte_reg;
    assign down.frame_end = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            byte_reg <= up.rx_byte;
            end_reg  <= up.frame_end;
        end
    end

endmodule

/* hdl/lcfp_core.sv */
// Frame state (count, sum, header, data bytes) and result evaluation on the last byte.
// Depends on lcfp_pkg, lcfp_byte_if, lcfp_result_if.
module lcfp_core
(
    input  logic          clk,
    input  logic          rst_n,
    lcfp_byte_if.sink     up,
    lcfp_result_if.source down
);

    logic [7:0]  count_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  length_reg;
    logic [15:0] axis_reg;
    logic [15:0] opcode_reg;
    logic [7:0]  data_reg [lcfp_pkg::DATA_DEPTH];

    logic [7:0]  count_next;
    logic        take;
    logic        is_data;
    logic [lcfp_pkg::DATA_IDX_W-1:0] data_off;
    logic        size_bad;
    logic [7:0]  dcount_full;
    logic [lcfp_pkg::DCOUNT_W-1:0] dcount;
    logic [63:0] payload;
    lcfp_pkg::lcfp_status_t status;

    assign take       = up.valid && up.ready;
    assign up.ready   = !up.frame_end || down.ready;
    assign count_next = (count_reg == lcfp_pkg::COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign data_off   = lcfp_pkg::DATA_IDX_W'(count_reg - 8'(lcfp_pkg::HEADER_BYTES));
    assign is_data    = (count_reg >= 8'(lcfp_pkg::HEADER_BYTES)) &&
                        (count_reg < 8'(lcfp_pkg::HEADER_BYTES + lcfp_pkg::DATA_DEPTH));

    assign size_bad = (count_next < 8'(lcfp_pkg::MIN_FRAME_BYTES)) ||
                      (count_next > 8'(lcfp_pkg::MAX_FRAME_BYTES)) ||
                      (({1'b0, length_reg} + 9'd2) != {1'b0, count_next});

    assign dcount_full = count_next - 8'(lcfp_pkg::MIN_FRAME_BYTES);
    assign dcount = (dcount_full > 8'(lcfp_pkg::DATA_DEPTH)) ?
                    lcfp_pkg::DCOUNT_W'(lcfp_pkg::DATA_DEPTH) :
                    dcount_full[lcfp_pkg::DCOUNT_W-1:0];

    always_comb
    begin
        payload = '0;
        for (int i = 0; i < lcfp_pkg::DATA_DEPTH; i++)
        begin
            if (lcfp_pkg::DCOUNT_W'(i) < dcount)
            begin
                payload[63-8*i -: 8] = data_reg[i];
            end
        end
    end

    always_comb
    begin
        if (size_bad)
        begin
            status = lcfp_pkg::STATUS_BAD_SIZE;
        end
        else if (sum_reg != up.rx_byte)
        begin
            status = lcfp_pkg::STATUS_BAD_SUM;
        end
        else
        begin
            status = lcfp_pkg::STATUS_OK;
        end
    end

    assign down.valid      = up.valid && up.frame_end;
    assign down.status     = status;
    assign down.frame_size = count_next;
    assign down.axis_id    = (status == lcfp_pkg::STATUS_OK) ?
                             {axis_reg[15:8], axis_reg[7:4]} : 12'd0;
    assign down.command_code = (status == lcfp_pkg::STATUS_OK) ? opcode_reg : 16'd0;
    assign down.data_count   = (status == lcfp_pkg::STATUS_OK) ? dcount : '0;
    assign down.data_payload = (status == lcfp_pkg::STATUS_OK) ? payload : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            length_reg <= '0;
            axis_reg   <= '0;
            opcode_reg <= '0;
        end
        else if (take)
        begin
            if (up.frame_end)
            begin
                count_reg  <= '0;
                sum_reg    <= '0;
                length_reg <= '0;
                axis_reg   <= '0;
                opcode_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_reg + up.rx_byte;
                unique case (count_reg)
                    lcfp_pkg::IDX_LENGTH:    length_reg       <= up.rx_byte;
                    lcfp_pkg::IDX_AXIS_HI:   axis_reg[15:8]   <= up.rx_byte;
                    lcfp_pkg::IDX_AXIS_LO:   axis_reg[7:0]    <= up.rx_byte;
                    lcfp_pkg::IDX_OPCODE_HI: opcode_reg[15:8] <= up.rx_byte;
                    lcfp_pkg::IDX_OPCODE_LO: opcode_reg[7:0]  <= up.rx_byte;
                    default: ;
                endcase
            end
        end
    end

    // data bytes need no reset; only entries written this frame are read
    always_ff @(posedge clk)
    begin
        if (take && !up.frame_end && is_data)
        begin
            data_reg[data_off] <= up.rx_byte;
        end
    end

endmodule

/* hdl/lcfp_out_stage.sv */
// Output register stage for result beats.
// Depends on lcfp_result_if.
module lcfp_out_stage
(
    input  logic          clk,
    input  logic          rst_n,
    lcfp_result_if.sink   up,
    lcfp_result_if.source down
);

    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [7:0]  size_reg;
    logic [11:0] axis_reg;
    logic [15:0] code_reg;
    logic [3:0]  count_reg;
    logic [63:0] payload_reg;

    assign up.ready          = !valid_reg || down.ready;
    assign down.valid        = valid_reg;
    assign down.status       = status_reg;
    assign down.frame_size   = size_reg;
    assign down.axis_id      = axis_reg;
    assign down.command_code = code_reg;
    assign down.data_count   = count_reg;
    assign down.data_payload = payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            status_reg  <= up.status;
            size_reg    <= up.frame_size;
            axis_reg    <= up.axis_id;
            code_reg    <= up.command_code;
            count_reg   <= up.data_count;
            payload_reg <= up.data_payload;
        end
    end

endmodule

/* hdl/length_checksum_frame_parser_unit.sv */
// A result beat is registered in the output stage once the core takes the frame_end beat from the input register.
// Throughput: one byte beat per cycle; input register, core, output register in line.
// Only the output register holding an untaken result can stall the byte channel.
// Reset (rst_n, async, active low): empty frame, both stage registers empty.
// Depends on lcfp_pkg, lcfp_byte_if, lcfp_result_if, lcfp_in_stage, lcfp_core,
// lcfp_out_stage.
module length_checksum_frame_parser_unit
(
    input  logic          clk,
    input  logic          rst_n,
    lcfp_byte_if.sink     rx,
    lcfp_result_if.source res
);

    lcfp_byte_if   byte_q ();
    lcfp_result_if res_d ();

    lcfp_in_stage u_in
    (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (rx),
        .down  (byte_q)
    );

    lcfp_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (byte_q),
        .down  (res_d)
    );

    lcfp_out_stage u_out
    (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (res_d),
        .down  (res)
    );

endmodule

/* hdl/lcfp_checker.sv */
// Port-level checks on result beats, bound to the top level.
// Depends on assert_macros.svh, lcfp_pkg, length_checksum_frame_parser_unit.
`include "assert_macros.svh"

module lcfp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  frame_size,
    input logic [11:0] axis_id,
    input logic [15:0] command_code,
    input logic [3:0]  data_count,
    input logic [63:0] data_payload
);

    logic         is_ok;
    logic         fields_zero;
    logic         size_consistent;
    logic         out_stall;
    logic [105:0] beat_bits;

    assign is_ok = (status == lcfp_pkg::STATUS_OK);
    assign fields_zero = (axis_id == 12'd0) && (command_code == 16'd0) &&
                         (data_count == 4'd0) && (data_payload == 64'd0);
    assign size_consistent = (frame_size >= 8'(lcfp_pkg::MIN_FRAME_BYTES)) &&
                             (frame_size <= 8'(lcfp_pkg::MAX_FRAME_BYTES)) &&
                             ({4'd0, data_count} ==
                              frame_size - 8'(lcfp_pkg::MIN_FRAME_BYTES));
    assign out_stall = out_valid && !out_ready;
    assign beat_bits = {status, frame_size, axis_id, command_code, data_count, data_payload};

    `LCFP_ASSERT_NOW(a_status_code, out_valid, status != 2'd3, "undefined status code")

    `LCFP_ASSERT_NOW(a_err_fields_zero, out_valid && !is_ok, fields_zero, "error beat with data")

    `LCFP_ASSERT_NOW(a_ok_size, out_valid && is_ok, size_consistent, "ok beat with bad size")

    `LCFP_ASSERT_NEXT(a_hold, out_stall, out_valid && $stable(beat_bits), "stalled beat changed")

endmodule

bind length_checksum_frame_parser_unit lcfp_checker u_lcfp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .status       (res.status),
    .frame_size   (res.frame_size),
    .axis_id      (res.axis_id),
    .command_code (res.command_code),
    .data_count   (res.data_count),
    .data_payload (res.data_payload)
);

/* tb/length_checksum_frame_parser_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for length_checksum_frame_parser_unit: frames of byte beats in, parsed results out,
// checked field by field against an in-bench frame predictor under random idling and stalls.
// Depends on lcfp_pkg, lcfp_byte_if, lcfp_result_if and the parser RTL.
module length_checksum_frame_parser_unit_tb;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } rx_beat_t;

    typedef struct {
        lcfp_pkg::lcfp_status_t status;
        logic [7:0]   frame_size;
        logic [11:0]  axis_id;
        logic [15:0]  command_code;
        logic [3:0]   data_count;
        logic [63:0]  data_payload;
    } frame_result_t;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_LEN
    } frame_kind_t;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 360;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lcfp_byte_if   rx();
    lcfp_result_if res();

    rx_beat_t      pending_beats[$];
    frame_result_t expected_results[$];
    rx_beat_t      next_beat;
    frame_result_t oldest_result;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    // frame tracker state
    logic [7:0]  fp_count;
    logic [7:0]  fp_sum;
    logic [7:0]  fp_length;
    logic [15:0] fp_axis;
    logic [15:0] fp_opcode;
    logic [7:0]  fp_data [lcfp_pkg::DATA_DEPTH];

    length_checksum_frame_parser_unit u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res)
    );

    always #4 clk = ~clk;

    function automatic void clear_frame_tracker();
        fp_count  = '0;
        fp_sum    = '0;
        fp_length = '0;
        fp_axis   = '0;
        fp_opcode = '0;
        for (int i = 0; i < lcfp_pkg::DATA_DEPTH; i++)
        begin
            fp_data[i] = '0;
        end
    endfunction

    function automatic void track_rx_byte(input logic [7:0] b, input logic last);
        logic [7:0]    idx;
        frame_result_t r;
        int            dcount;
        idx = fp_count;
        if (fp_count != lcfp_pkg::COUNT_MAX)
        begin
            fp_count = fp_count + 8'd1;
        end
        if (!last)
        begin
            fp_sum = fp_sum + b;
            if (idx == lcfp_pkg::IDX_LENGTH)
                fp_length = b;
            else if (idx == lcfp_pkg::IDX_AXIS_HI)
                fp_axis[15:8] = b;
            else if (idx == lcfp_pkg::IDX_AXIS_LO)
                fp_axis[7:0] = b;
            else if (idx == lcfp_pkg::IDX_OPCODE_HI)
                fp_opcode[15:8] = b;
            else if (idx == lcfp_pkg::IDX_OPCODE_LO)
                fp_opcode[7:0] = b;
            else if (idx >= lcfp_pkg::HEADER_BYTES &&
                     idx < lcfp_pkg::HEADER_BYTES + lcfp_pkg::DATA_DEPTH)
                fp_data[idx - lcfp_pkg::HEADER_BYTES] = b;
            return;
        end
        r.status       = lcfp_pkg::STATUS_OK;
        r.frame_size   = fp_count;
        r.axis_id      = '0;
        r.command_code = '0;
        r.data_count   = '0;
        r.data_payload = '0;
        if (int'(fp_count) < lcfp_pkg::MIN_FRAME_BYTES ||
            int'(fp_count) > lcfp_pkg::MAX_FRAME_BYTES ||
            int'(fp_length) + 2 != int'(fp_count))
        begin
            r.status = lcfp_pkg::STATUS_BAD_SIZE;
        end
        else if (fp_sum != b)
        begin
            r.status = lcfp_pkg::STATUS_BAD_SUM;
        end
        else
        begin
            dcount = int'(fp_count) - lcfp_pkg::MIN_FRAME_BYTES;
            if (dcount > lcfp_pkg::DATA_DEPTH)
                dcount = lcfp_pkg::DATA_DEPTH;
            for (int i = 0; i < dcount; i++)
            begin
                r.data_payload[63 - 8 * i -: 8] = fp_data[i];
            end
            r.axis_id      = {fp_axis[15:8], fp_axis[7:4]};
            r.command_code = fp_opcode;
            r.data_count   = 4'(dcount);
        end
        expected_results.push_back(r);
        clear_frame_tracker();
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                         input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // fill < 0 gives random body bytes
    function automatic int queue_frame(input int size, input frame_kind_t kind,
                                       input int fill);
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        for (int i = 0; i < size - 1; i++)
        begin
            b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            if (i == 0)
            begin
                b = 8'(size - 2);
                if (kind == FRAME_BAD_LEN)
                    b = b + 8'($urandom_range(1, 255));
            end
            sum = sum + b;
            pending_beats.push_back('{value: b, last: 1'b0});
        end
        b = sum;
        if (kind == FRAME_BAD_SUM)
            b = b + 8'($urandom_range(1, 255));
        pending_beats.push_back('{value: b, last: 1'b1});
        return size;
    endfunction

    function automatic int queue_random_frame();
        int pick;
        pick = $urandom_range(99);
        if (pick < 62)
            return queue_frame($urandom_range(6, 14), FRAME_GOOD, -1);
        if (pick < 74)
            return queue_frame($urandom_range(6, 14), FRAME_BAD_SUM, -1);
        if (pick < 84)
            return queue_frame($urandom_range(6, 14), FRAME_BAD_LEN, -1);
        if (pick < 92)
            return queue_frame($urandom_range(1, 5), frame_kind_t'($urandom_range(2)), -1);
        return queue_frame($urandom_range(15, 40), frame_kind_t'($urandom_range(2)), -1);
    endfunction

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx.valid     <= 1'b0;
            rx.rx_byte   <= '0;
            rx.frame_end <= 1'b0;
        end
        else if (!rx.valid || rx.ready)
        begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_beat = pending_beats.pop_front();
                rx.valid     <= 1'b1;
                rx.rx_byte   <= next_beat.value;
                rx.frame_end <= next_beat.last;
            end
            else
            begin
                rx.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: results are checked before the same edge's byte is tracked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no frame pending: status %0h size %0h",
                           res.status, res.frame_size);
                    error_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    check_field("status", 64'(oldest_result.status), 64'(res.status));
                    check_field("frame_size", 64'(oldest_result.frame_size),
                                64'(res.frame_size));
                    check_field("axis_id", 64'(oldest_result.axis_id), 64'(res.axis_id));
                    check_field("command_code", 64'(oldest_result.command_code),
                                64'(res.command_code));
                    check_field("data_count", 64'(oldest_result.data_count),
                                64'(res.data_count));
                    check_field("data_payload", oldest_result.data_payload,
                                res.data_payload);
                end
            end
            if (rx.valid && rx.ready)
            begin
                track_rx_byte(rx.rx_byte, rx.frame_end);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[length_checksum_frame_parser_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int phase_bytes;
        rx.valid     = 1'b0;
        rx.rx_byte   = '0;
        rx.frame_end = 1'b0;
        res.ready    = 1'b0;
        clear_frame_tracker();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
                default: begin src_idle_pct = 20; snk_stall_pct = 20; end
            endcase
            phase_bytes = 0;
            if (phase == 0)
            begin
                // single-byte frame, minimal and maximal good frames, bad checksum
                phase_bytes += queue_frame(1, FRAME_GOOD, -1);
                phase_bytes += queue_frame(lcfp_pkg::MIN_FRAME_BYTES, FRAME_GOOD, 0);
                phase_bytes += queue_frame(lcfp_pkg::MAX_FRAME_BYTES, FRAME_GOOD, 255);
                phase_bytes += queue_frame(lcfp_pkg::MIN_FRAME_BYTES, FRAME_BAD_SUM, -1);
            end
            if (phase == 2)
            begin
                // byte count saturation
                phase_bytes += queue_frame($urandom_range(256, 300), FRAME_GOOD, -1);
            end
            while (phase_bytes < PHASE_BYTES)
            begin
                phase_bytes += queue_random_frame();
            end
            // sender holds off until every result of the phase is back
            while (pending_beats.size() != 0 || rx.valid || expected_results.size() != 0)
            begin
                @(posedge clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[length_checksum_frame_parser_unit] OK");
        else
            $display("[length_checksum_frame_parser_unit] ERROR");
        $finish;
    end

endmodule
